// ----- rtl/mac_address_dedup_filter_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the duplicate address filter.
// Shorthand for clocked implications that are switched off during reset.
// ----------------------------------------------------------------------------
`ifndef MAC_ADDRESS_DEDUP_FILTER_MACROS_SVH
`define MAC_ADDRESS_DEDUP_FILTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MDF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mdf_pkg.sv -----
// ----------------------------------------------------------------------------
// Duplicate address filter package
// Shared widths, character codes, item types and the hex digit decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mdf_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 256;

    localparam int CHAR_W   = 8;
    localparam int KEY_W    = 48;
    localparam int THRESH_W = 9;
    localparam int CLEAR_W  = 16;
    localparam int DIGIT_W  = 4;

    localparam logic [THRESH_W-1:0] THRESH_RESET   = 9'd256;
    localparam logic [DIGIT_W-1:0]  DIGITS_PER_KEY = 4'd12;

    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] HEX_TEN    = 8'd10;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } char_item_t;

    typedef struct packed {
        logic               is_new;
        logic               parse_ok;
        logic [KEY_W-1:0]   address_key;
        logic               table_cleared;
        logic [CLEAR_W-1:0] clear_total;
    } result_t;

    typedef struct packed {
        logic             ok;
        logic [KEY_W-1:0] key;
    } parse_view_t;

    typedef struct packed {
        logic             valid;
        logic             found;
        logic [KEY_W-1:0] key;
    } token_t;

    typedef struct packed {
        logic               valid;
        logic [DIGIT_W-1:0] value;
    } hex_digit_t;

    function automatic hex_digit_t decode_hex(logic [CHAR_W-1:0] c);
        hex_digit_t d;
        d.valid = 1'b1;
        d.value = '0;
        case (c) inside
            [CHAR_0:CHAR_9]:   d.value = DIGIT_W'(c - CHAR_0);
            [CHAR_LA:CHAR_LF]: d.value = DIGIT_W'(c - CHAR_LA + HEX_TEN);
            [CHAR_UA:CHAR_UF]: d.value = DIGIT_W'(c - CHAR_UA + HEX_TEN);
            default:           d.valid = 1'b0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mdf_parse.sv -----
// ----------------------------------------------------------------------------
// Address text parser
// Skips separators, shifts hex digits into the key and tracks parse errors.
// ----------------------------------------------------------------------------
`default_nettype none

module mdf_parse
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               take,
    input  wire mdf_pkg::char_item_t item,
    output mdf_pkg::parse_view_t    view
);

    logic [mdf_pkg::KEY_W-1:0]   acc_reg, acc_next;
    logic [mdf_pkg::DIGIT_W-1:0] cnt_reg, cnt_next;
    logic                        err_reg, err_next;
    logic                        is_sep;
    mdf_pkg::hex_digit_t         digit;

    always_comb
    begin
        digit    = mdf_pkg::decode_hex(item.char_code);
        is_sep   = (item.char_code == mdf_pkg::CHAR_COLON) ||
                   (item.char_code == mdf_pkg::CHAR_DASH);
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        err_next = err_reg;
        if (!is_sep)
        begin
            if (!digit.valid || (cnt_reg >= mdf_pkg::DIGITS_PER_KEY))
            begin
                err_next = 1'b1;
            end
            else
            begin
                acc_next = {acc_reg[mdf_pkg::KEY_W-mdf_pkg::DIGIT_W-1:0], digit.value};
                cnt_next = cnt_reg + 4'd1;
            end
        end
        view.ok  = !err_next && (cnt_next == mdf_pkg::DIGITS_PER_KEY);
        view.key = view.ok ? acc_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
            err_reg <= 1'b0;
        end
        else if (take)
        begin
            if (item.last_char)
            begin
                acc_reg <= '0;
                cnt_reg <= '0;
                err_reg <= 1'b0;
            end
            else
            begin
                acc_reg <= acc_next;
                cnt_reg <= cnt_next;
                err_reg <= err_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mdf_cell.sv -----
// ----------------------------------------------------------------------------
// Table cell
// Holds one stored key, compares it with the passing search token and hands
// the token on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module mdf_cell
#(
    parameter int CELL_INDEX = 0,
    parameter int COUNT_W    = 9
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire mdf_pkg::token_t           tok_in,
    input  wire logic [COUNT_W-1:0]        count,
    input  wire logic                      wr_en,
    input  wire logic [mdf_pkg::KEY_W-1:0] wr_key,
    output mdf_pkg::token_t                tok_out
);

    logic [mdf_pkg::KEY_W-1:0] entry_reg;
    logic                      valid_reg;
    logic                      found_reg;
    logic [mdf_pkg::KEY_W-1:0] key_reg;
    logic                      active;
    logic                      hit;

    assign active = COUNT_W'(CELL_INDEX) < count;
    assign hit    = active && (entry_reg == tok_in.key);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= tok_in.found | hit;
        key_reg   <= tok_in.key;
        if (wr_en)
        begin
            entry_reg <= wr_key;
        end
    end

    assign tok_out.valid = valid_reg;
    assign tok_out.found = found_reg;
    assign tok_out.key   = key_reg;

endmodule

`default_nettype wire

// ----- rtl/mac_address_dedup_filter.sv -----
// ----------------------------------------------------------------------------
// Duplicate address filter
// Parses textual hardware addresses and reports whether each one is new,
// keeping the seen keys in a row of cells that a search token walks through.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Carries
//  request   start / busy           char_code, last_char
//  result    done (one cycle)       is_new, parse_ok, address_key,
//                                   table_cleared, clear_total
//  config    cfg_valid / cfg_ready  clear_threshold
//
// A character that is not the last of its address only updates the parser; the filter stays idle.
// The last character of an unparseable address gives a registered result without a search.
// The last character of a parsed address starts a search, and busy stays high until
// the search token has passed one cell per cycle down the row of cells.
// Reset leaves the table empty; no clearing pass is needed.
// A result is shown for exactly one cycle and cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mac_address_dedup_filter_macros.svh"

module mac_address_dedup_filter
#(
    parameter int TABLE_DEPTH = mdf_pkg::TABLE_DEPTH_DEFAULT
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire mdf_pkg::char_item_t          request,
    output logic                              done,
    output mdf_pkg::result_t                  result,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [mdf_pkg::THRESH_W-1:0] cfg_data
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int LW = (CW > mdf_pkg::THRESH_W) ? CW : mdf_pkg::THRESH_W;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_SEARCH = 2'b10
    } state_t;

    state_t                        state_reg, state_next;
    logic [mdf_pkg::THRESH_W-1:0]  thr_reg;
    logic [CW-1:0]                 count_reg, count_next;
    logic [mdf_pkg::CLEAR_W-1:0]   total_reg, total_next;
    logic                          done_reg, done_next;
    mdf_pkg::result_t              res_reg, res_next;
    mdf_pkg::token_t               launch_reg, launch_next;
    logic [mdf_pkg::KEY_W-1:0]     key_reg, key_next;
    logic                          cleared_reg, cleared_next;

    logic                          accept;
    logic                          clear_now;
    logic                          write_now;
    mdf_pkg::parse_view_t          view;
    mdf_pkg::token_t               tok [0:TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]        wr_en;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = res_reg;

    mdf_parse u_parse
    (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (accept),
        .item  (request),
        .view  (view)
    );

    assign tok[0] = launch_reg;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            assign wr_en[gi] = write_now && (count_reg[IW-1:0] == IW'(gi));

            mdf_cell
            #(
                .CELL_INDEX (gi),
                .COUNT_W    (CW)
            )
            u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .tok_in  (tok[gi]),
                .count   (count_reg),
                .wr_en   (wr_en[gi]),
                .wr_key  (key_reg),
                .tok_out (tok[gi+1])
            );
        end
    endgenerate

    assign clear_now = (LW'(count_reg) >= LW'(thr_reg)) ||
                       (LW'(count_reg) >= LW'(TABLE_DEPTH));
    assign write_now = (state_reg == ST_SEARCH) && tok[TABLE_DEPTH].valid &&
                       !tok[TABLE_DEPTH].found && (count_reg != CW'(TABLE_DEPTH));

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        done_next    = 1'b0;
        res_next     = res_reg;
        launch_next  = launch_reg;
        launch_next.valid = 1'b0;
        key_next     = key_reg;
        cleared_next = cleared_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && request.last_char)
                begin
                    if (clear_now)
                    begin
                        count_next = '0;
                        total_next = total_reg + 16'd1;
                    end
                    if (view.ok)
                    begin
                        launch_next.valid = 1'b1;
                        launch_next.found = 1'b0;
                        launch_next.key   = view.key;
                        key_next          = view.key;
                        cleared_next      = clear_now;
                        state_next        = ST_SEARCH;
                    end
                    else
                    begin
                        done_next              = 1'b1;
                        res_next.is_new        = 1'b1;
                        res_next.parse_ok      = 1'b0;
                        res_next.address_key   = '0;
                        res_next.table_cleared = clear_now;
                        res_next.clear_total   = total_next;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (tok[TABLE_DEPTH].valid)
                begin
                    if (write_now)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    done_next              = 1'b1;
                    res_next.is_new        = !tok[TABLE_DEPTH].found;
                    res_next.parse_ok      = 1'b1;
                    res_next.address_key   = key_reg;
                    res_next.table_cleared = cleared_reg;
                    res_next.clear_total   = total_reg;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            thr_reg    <= mdf_pkg::THRESH_RESET;
            count_reg  <= '0;
            total_reg  <= '0;
            done_reg   <= 1'b0;
            launch_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            total_reg  <= total_next;
            done_reg   <= done_next;
            launch_reg <= launch_next;
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg     <= res_next;
        key_reg     <= key_next;
        cleared_reg <= cleared_next;
    end

    `MDF_ASSERT_SAME(a_key_zero_on_error, done && !result.parse_ok,
        result.is_new && (result.address_key == '0), "failed parse must report a new zero key")
    `MDF_ASSERT_NEXT(a_search_ends, (state_reg == ST_SEARCH) && tok[TABLE_DEPTH].valid,
        done && (state_reg == ST_IDLE), "finished search must give a result")
    `MDF_ASSERT_SAME(a_launch_in_search, launch_reg.valid,
        state_reg == ST_SEARCH, "search token launched outside a search")
    `MDF_ASSERT_SAME(a_count_bound, 1'b1,
        count_reg <= CW'(TABLE_DEPTH), "stored key count beyond table depth")

endmodule

`default_nettype wire
